/* rtl/core/tolerant_vote_table_mode_assert.svh */
// assertion macros for the tolerant vote table
`ifndef TOLERANT_VOTE_TABLE_MODE_ASSERT_SVH
`define TOLERANT_VOTE_TABLE_MODE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TVTM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define TVTM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/tvtm_pkg.sv */
// package: types and constants of the tolerant vote table
`default_nettype none

package tvtm_pkg;

	localparam int VALUE_W  = 32;
	localparam int WEIGHT_W = 16;
	localparam int COUNT_W  = 24;
	localparam int TOL_W    = 16;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [TOL_W-1:0]   TOL_RESET = TOL_W'(1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE
	} state_t;

	// count plus weight, clamped at the top of the count range
	function automatic logic [COUNT_W-1:0] sat_add(
		input logic [COUNT_W-1:0]  cnt,
		input logic [WEIGHT_W-1:0] w
	);
		logic [COUNT_W:0] sum;
		sum = {1'b0, cnt} + (COUNT_W + 1)'(w);
		return sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/tolerant_vote_table_mode.sv */
// top level: tolerant vote table with sequential scan and running leader
//
//  channel   direction  handshake                    payload
//  config    in         tolerance_we                 tolerance_wdata
//  vote      in         start && !busy               vote_value, vote_weight
//  result    out        done (one cycle, no stall)   merged, dropped, best_valid,
//                                                    best_value, best_count
//
// - an item stays busy through a scan of the stored entries in use (at most ENTRIES)
//   and a write-back; the scan is skipped when the table is empty and ends early when
//   a newer entry matches; the result strobes in the cycle after the write-back
// - the time is set by the single memory read port: one entry per cycle is read
//   newest to oldest, through one shared subtract/compare unit
// - the scan stops at the first entry within tolerance; then a write-back state
// - reset clears the entry count, the leader and the tolerance (to 1) at once;
//   no clearing pass, entries beyond the count are never read
// - busy falls in the strobe cycle, so the next start may be taken there
`default_nettype none

module tolerant_vote_table_mode #(
	parameter int ENTRIES = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           tolerance_we,
	input  wire logic [tvtm_pkg::TOL_W-1:0]     tolerance_wdata,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic signed [tvtm_pkg::VALUE_W-1:0]  vote_value,
	input  wire logic [tvtm_pkg::WEIGHT_W-1:0]  vote_weight,
	output logic                                done,
	output logic                                merged,
	output logic                                dropped,
	output logic                                best_valid,
	output logic signed [tvtm_pkg::VALUE_W-1:0] best_value,
	output logic [tvtm_pkg::COUNT_W-1:0]        best_count
);

	import tvtm_pkg::*;

	`include "tolerant_vote_table_mode_assert.svh"

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int USED_W = $clog2(ENTRIES + 1);
	localparam logic [USED_W-1:0] FULL = USED_W'(ENTRIES);

	// entry storage
	logic signed [VALUE_W-1:0] vals_mem [ENTRIES];
	logic [COUNT_W-1:0]        cnts_mem [ENTRIES];

	state_t state_q, state_nx;

	// control state
	logic [TOL_W-1:0]  tol_q;
	logic [USED_W-1:0] used_q;
	logic              iss_done_q;
	logic              rd_vld_s1;
	logic              done_q;
	logic              merged_q;
	logic              dropped_q;
	logic              best_valid_q;
	logic signed [VALUE_W-1:0] best_val_q;
	logic [COUNT_W-1:0]        best_cnt_q;

	// item datapath
	logic signed [VALUE_W-1:0] v_q;
	logic [WEIGHT_W-1:0]       w_q;
	logic [IDX_W-1:0]          ptr_q;
	logic                      hit_q;
	logic [IDX_W-1:0]          hit_idx_q;
	logic signed [VALUE_W-1:0] new_val_q;
	logic [COUNT_W-1:0]        new_cnt_q;

	// registered read port
	logic signed [VALUE_W-1:0] rd_val_s1;
	logic [COUNT_W-1:0]        rd_cnt_s1;
	logic [IDX_W-1:0]          rd_idx_s1;

	logic accept;
	logic rd_en;
	logic wr_en;
	logic full;
	logic hit;
	logic scan_end;
	logic new_wins;
	logic signed [VALUE_W:0] diff;
	logic [VALUE_W:0]        abs_diff;
	logic [IDX_W-1:0]        wr_addr;

	assign accept = start && !busy;
	assign full   = (used_q == FULL);

	// shared distance unit: |stored - vote| at full precision against tolerance
	assign diff     = {rd_val_s1[VALUE_W-1], rd_val_s1} - {v_q[VALUE_W-1], v_q};
	assign abs_diff = diff[VALUE_W] ? (VALUE_W + 1)'(-diff) : (VALUE_W + 1)'(diff);
	assign hit      = rd_vld_s1 && (abs_diff < (VALUE_W + 1)'(tol_q));

	// scan ends on a match or after comparing the oldest entry
	assign scan_end = rd_vld_s1 && (hit || (rd_idx_s1 == '0));

	assign wr_addr = hit_q ? hit_idx_q : used_q[IDX_W-1:0];

	// leader after this item: only the touched entry changed, and it only grew
	assign new_wins = (used_q == '0) || (new_cnt_q > best_cnt_q) ||
		((new_cnt_q == best_cnt_q) && (new_val_q < best_val_q));

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nx = (used_q == '0) ? ST_WRITE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_nx = ST_WRITE;
				end
			end
			ST_WRITE: begin
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		busy  = 1'b1;
		rd_en = 1'b0;
		wr_en = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_SCAN: begin
				rd_en = !iss_done_q && !scan_end;
			end
			ST_WRITE: begin
				wr_en = hit_q || !full;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			tol_q        <= TOL_RESET;
			used_q       <= '0;
			iss_done_q   <= 1'b0;
			rd_vld_s1    <= 1'b0;
			done_q       <= 1'b0;
			merged_q     <= 1'b0;
			dropped_q    <= 1'b0;
			best_valid_q <= 1'b0;
			best_val_q   <= '0;
			best_cnt_q   <= '0;
		end else begin
			state_q   <= state_nx;
			rd_vld_s1 <= rd_en;
			done_q    <= (state_q == ST_WRITE);
			if (tolerance_we) begin
				tol_q <= tolerance_wdata;
			end
			if (accept) begin
				iss_done_q <= 1'b0;
			end else if (rd_en && (ptr_q == '0)) begin
				iss_done_q <= 1'b1;
			end
			if (state_q == ST_WRITE) begin
				merged_q  <= hit_q;
				dropped_q <= !hit_q && full;
				if (wr_en) begin
					best_valid_q <= 1'b1;
					if (!hit_q) begin
						used_q <= used_q + USED_W'(1);
					end
					if (new_wins) begin
						best_val_q <= new_val_q;
						best_cnt_q <= new_cnt_q;
					end
				end
			end
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q       <= vote_value;
			w_q       <= vote_weight;
			ptr_q     <= IDX_W'(used_q - USED_W'(1));
			hit_q     <= 1'b0;
			hit_idx_q <= '0;
			new_val_q <= vote_value;
			new_cnt_q <= COUNT_W'(vote_weight);
		end else begin
			if (rd_en && (ptr_q != '0)) begin
				ptr_q <= ptr_q - IDX_W'(1);
			end
			if ((state_q == ST_SCAN) && hit) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rd_idx_s1;
				new_val_q <= rd_val_s1;
				new_cnt_q <= sat_add(rd_cnt_s1, w_q);
			end
		end
	end

	// entry memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			cnts_mem[wr_addr] <= new_cnt_q;
			if (!hit_q) begin
				vals_mem[wr_addr] <= new_val_q;
			end
		end
		if (rd_en) begin
			rd_val_s1 <= vals_mem[ptr_q];
			rd_cnt_s1 <= cnts_mem[ptr_q];
			rd_idx_s1 <= ptr_q;
		end
	end

	assign done       = done_q;
	assign merged     = merged_q;
	assign dropped    = dropped_q;
	assign best_valid = best_valid_q;
	assign best_value = best_val_q;
	assign best_count = best_cnt_q;

	// checks
	`TVTM_ASSERT_NOW(a_merge_drop_excl, done_q, !(merged_q && dropped_q), "merged and dropped together")
	`TVTM_ASSERT_NOW(a_done_has_leader, done_q, best_valid_q, "result without a leader")
	`TVTM_ASSERT_NOW(a_used_bound, 1'b1, used_q <= FULL, "entry count past table size")
	`TVTM_ASSERT_NEXT(a_accept_busy, accept, busy, "accepted item not in progress")
	`TVTM_ASSERT_NEXT(a_write_done, state_q == ST_WRITE, done_q, "write-back without result")
	`TVTM_ASSERT_NOW(a_no_write_scan, state_q == ST_SCAN, !wr_en, "memory write during scan")

endmodule

`default_nettype wire

/* dv/tolerant_vote_table_mode_test.sv */
// testbench for the tolerant vote table: directed and random votes against a running predictor
`timescale 1ns / 100ps

module tolerant_vote_table_mode_test;
	import tvtm_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 800000;
	// value that the heavy votes pile onto, so that one count reaches saturation
	localparam logic signed [VALUE_W-1:0] HOT_VALUE = '0;
	localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
	localparam logic [WEIGHT_W-1:0]       WEIGHT_MAX = '1;
	localparam logic [TOL_W-1:0]          TOL_MAX = '1;

	// one leader report as the block strobes it out
	typedef struct {
		logic                        merged;
		logic                        dropped;
		logic                        best_valid;
		logic signed [VALUE_W-1:0]   best_value;
		logic [COUNT_W-1:0]          best_count;
	} leader_report_t;

	logic                        clk;
	logic                        arst_n = 1'b0;
	logic                        tolerance_we = 1'b0;
	logic [TOL_W-1:0]            tolerance_wdata = '0;
	logic                        start = 1'b0;
	logic                        busy;
	logic signed [VALUE_W-1:0]   vote_value = '0;
	logic [WEIGHT_W-1:0]         vote_weight = '0;
	logic                        done;
	logic                        merged;
	logic                        dropped;
	logic                        best_valid;
	logic signed [VALUE_W-1:0]   best_value;
	logic [COUNT_W-1:0]          best_count;

	// predictor copy of the vote table and the tolerance register
	logic signed [VALUE_W-1:0]   tally_values [TABLE_DEPTH];
	logic [COUNT_W-1:0]          tally_counts [TABLE_DEPTH];
	int                          tally_used = 0;
	logic [TOL_W-1:0]            tol_shadow = TOL_RESET;

	// leader reports still owed by the block, oldest first
	leader_report_t              pending_reports [$];

	int                          error_count = 0;
	int                          votes_sent = 0;
	int                          merges_seen = 0;
	int                          drops_seen = 0;
	int                          saturated_seen = 0;
	int                          cycle_count = 0;
	// chance in percent that the sender holds off before an item
	int                          idle_pct = 0;

	tolerant_vote_table_mode #(
		.ENTRIES(TABLE_DEPTH)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.tolerance_we    (tolerance_we),
		.tolerance_wdata (tolerance_wdata),
		.start           (start),
		.busy            (busy),
		.vote_value      (vote_value),
		.vote_weight     (vote_weight),
		.done            (done),
		.merged          (merged),
		.dropped         (dropped),
		.best_valid      (best_valid),
		.best_value      (best_value),
		.best_count      (best_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tolerant_vote_table_mode_test: done, errors");
			$finish;
		end
	end

	// apply one vote to the table copy and work out the leader report it causes
	function automatic leader_report_t tally_vote(
		input logic signed [VALUE_W-1:0] v,
		input logic [WEIGHT_W-1:0]       w
	);
		leader_report_t           r;
		longint                   delta;
		logic [COUNT_W:0]         sum;
		logic signed [VALUE_W-1:0] lead_v;
		logic [COUNT_W-1:0]       lead_c;
		r.merged = 1'b0;
		r.dropped = 1'b0;
		// newest entry first; distance at 64 bits so extremes never wrap
		for (int k = tally_used - 1; k >= 0; k--) begin
			delta = longint'(tally_values[k]) - longint'(v);
			if (delta < 0)
				delta = -delta;
			if (delta < longint'(tol_shadow)) begin
				sum = {1'b0, tally_counts[k]} + (COUNT_W + 1)'(w);
				tally_counts[k] = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
				r.merged = 1'b1;
				break;
			end
		end
		if (!r.merged) begin
			if (tally_used < TABLE_DEPTH) begin
				tally_values[tally_used] = v;
				tally_counts[tally_used] = COUNT_W'(w);
				tally_used++;
			end else begin
				r.dropped = 1'b1;
			end
		end
		// highest count leads, smaller value wins a tie
		lead_v = '0;
		lead_c = '0;
		for (int i = 0; i < tally_used; i++) begin
			if (i == 0 || tally_counts[i] > lead_c ||
			    (tally_counts[i] == lead_c && tally_values[i] < lead_v)) begin
				lead_c = tally_counts[i];
				lead_v = tally_values[i];
			end
		end
		r.best_valid = (tally_used > 0);
		r.best_value = lead_v;
		r.best_count = lead_c;
		return r;
	endfunction

	task automatic check_field(
		input string                name,
		input logic signed [63:0]   want,
		input logic signed [63:0]   got
	);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endtask

	// every strobed report is matched against the oldest outstanding vote
	always @(posedge clk) begin : check_reports
		leader_report_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_reports.size() == 0) begin
				$error("leader report strobed with no vote outstanding");
				error_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("merged", want.merged, merged);
				check_field("dropped", want.dropped, dropped);
				check_field("best_valid", want.best_valid, best_valid);
				check_field("best_value", want.best_value, best_value);
				check_field("best_count", want.best_count, best_count);
				merges_seen += want.merged;
				drops_seen += want.dropped;
				if (want.best_count == COUNT_MAX)
					saturated_seen++;
			end
		end
	end

	// present one vote, optionally after an idle gap, and wait until it is taken
	task automatic send_vote(
		input logic signed [VALUE_W-1:0] v,
		input logic [WEIGHT_W-1:0]       w
	);
		int gap;
		gap = 0;
		// gap length spans the whole busy window so start lands on every scan phase
		if (idle_pct != 0 && $urandom_range(99) < idle_pct)
			gap = $urandom_range(1, tally_used + 4);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		vote_value <= v;
		vote_weight <= w;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_reports.push_back(tally_vote(v, w));
		votes_sent++;
	endtask

	// drop start after the last item and wait for every report to come back
	task automatic settle();
		start <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
	endtask

	// only called with the table idle, so the copy can follow at once
	task automatic write_tolerance(input logic [TOL_W-1:0] tol);
		tolerance_we <= 1'b1;
		tolerance_wdata <= tol;
		@(posedge clk);
		tolerance_we <= 1'b0;
		tol_shadow = tol;
	endtask

	// reset tolerance of 1: only exact repeats merge; zero weight and a count tie
	task automatic test_first_votes();
		send_vote(32'sd0, 16'd5);
		send_vote(32'sd0, 16'd0);
		send_vote(32'sd1, 16'd5);
		send_vote(-32'sd1, 16'd0);
		settle();
	endtask

	// value extremes: no wrap between the largest and smallest values
	task automatic test_value_extremes();
		write_tolerance(TOL_W'(2));
		send_vote(VALUE_MAX, WEIGHT_MAX);
		send_vote(VALUE_MIN, WEIGHT_MAX);
		send_vote(VALUE_MAX - 32'sd1, 16'd1);
		send_vote(VALUE_MIN + 32'sd1, 16'd0);
		settle();
	endtask

	// widest tolerance: newest match wins, distance equal to tolerance does not merge
	task automatic test_tolerance_extremes();
		write_tolerance(TOL_MAX);
		send_vote(32'sd2, 16'd3);
		send_vote(VALUE_MIN + 32'sd65535, 16'd4);
		send_vote(VALUE_MIN + 32'sd65536, 16'd1);
		send_vote(VALUE_MAX - 32'sd65534, 16'd2);
		settle();
	endtask

	// zero tolerance makes duplicate entries; afterward the newest duplicate absorbs
	task automatic test_zero_tolerance();
		write_tolerance('0);
		send_vote(32'sd1, 16'd7);
		send_vote(32'sd0, 16'd9);
		settle();
		write_tolerance(TOL_W'(1));
		send_vote(32'sd1, 16'd2);
		settle();
	endtask

	// mostly heavy votes on one value and near misses around stored entries,
	// the rest random values that fill the table and then get dropped
	task automatic test_random_votes(
		input logic [TOL_W-1:0] tol,
		input int               idle,
		input int               count
	);
		int                        pick;
		int                        span;
		int                        offset;
		logic signed [VALUE_W-1:0] v;
		logic [WEIGHT_W-1:0]       w;
		write_tolerance(tol);
		idle_pct = idle;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				v = HOT_VALUE;
				w = WEIGHT_MAX - WEIGHT_W'($urandom_range(0, 255));
			end else if (pick < 80) begin
				// straddle the tolerance edge of a stored entry
				span = int'(tol_shadow) + 2;
				offset = int'($urandom_range(0, 2 * span)) - span;
				v = tally_values[$urandom_range(0, tally_used - 1)] + VALUE_W'(offset);
				w = (pick % 8 == 0) ? '0 : WEIGHT_W'($urandom_range(0, 65535));
			end else begin
				v = $urandom;
				w = WEIGHT_W'($urandom);
			end
			send_vote(v, w);
		end
		settle();
		idle_pct = 0;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_votes();
		test_value_extremes();
		test_tolerance_extremes();
		test_zero_tolerance();

		// sender steady, sender idle often, receiver stall phase (no stall possible
		// on this port, so the sender stays steady), then the sender idle lightly
		test_random_votes(TOL_W'(1), 0, 258);
		test_random_votes(TOL_MAX, 59, 258);
		test_random_votes(TOL_W'($urandom_range(2, 5000)), 0, 258);
		test_random_votes(TOL_W'(300), 8, 258);

		// let any stray strobe show up before the verdict
		repeat (TABLE_DEPTH + 8) @(posedge clk);

		$display("votes: %0d sent, %0d merged, %0d dropped, %0d reports at a saturated count",
			votes_sent, merges_seen, drops_seen, saturated_seen);
		$display("tolerance swept from 0 to 65535 with steady and gapped vote streams");
		if (error_count == 0) begin
			$display("tolerant_vote_table_mode_test: done, clean");
		end else begin
			$display("tolerant_vote_table_mode_test: done, errors");
		end
		$finish;
	end

endmodule
